[hw/rtl/ffba_pkg.sv]
`default_nettype none
package ffba_pkg;

  localparam int MAX_BLOCKS_DEF = 256;
  localparam int META_BYTES_DEF = 32;
  localparam logic [26:0] MAX_REQUEST_RST = 27'd100000000;
  localparam logic [31:0] HEAP_CAP_RST = 32'hFFFF_FFFF;
  localparam int Q_DEPTH = 2;

  typedef enum logic [1:0] {
    K_ALLOC   = 2'd0,
    K_CALLOC  = 2'd1,
    K_FREE    = 2'd2,
    K_REALLOC = 2'd3
  } kind_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_REJ  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [2:0] ADDR_MAX_REQ  = 3'd0;
  localparam logic [2:0] ADDR_HEAP_CAP = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [26:0] request_size;
    logic [26:0] element_count;
    logic        handle_valid;
    logic [7:0]  handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  result_handle;
    logic [31:0] data_offset;
    logic [26:0] copy_bytes;
    logic [26:0] clear_bytes;
    logic [8:0]  allocated_blocks;
    logic [8:0]  free_blocks;
    logic [31:0] allocated_bytes;
    logic [31:0] free_bytes;
  } out_item_t;

  // classified request handed from front to back
  typedef struct packed {
    kind_t       kind;
    logic        reject;
    logic [26:0] size;
    logic [26:0] clear;
    logic        hvalid;
    logic [7:0]  hin;
  } cmd_t;

  typedef struct packed {
    logic [26:0] len;
    logic        free;
    logic [31:0] start;
  } entry_t;

endpackage
`default_nettype wire

[hw/rtl/ffba_front.sv]
`default_nettype none
module ffba_front
  import ffba_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        acc,
  input  wire in_item_t    item,
  input  wire logic [26:0] max_request,
  input  wire logic        q_full,
  output cmd_t             push_cmd,
  output logic             push,
  output logic             busy
);

  logic        v1_r, v1_nxt, v2_r, v2_nxt;
  in_item_t    it1_r, it2_r;
  logic [53:0] prod_r;
  logic        adv2;
  logic        size_bad;

  assign push = v2_r && !q_full;
  assign adv2 = push || !v2_r;
  assign busy = v1_r || v2_r;

  always_comb begin
    v1_nxt = v1_r;
    v2_nxt = v2_r;
    if (adv2) begin
      v2_nxt = v1_r;
      v1_nxt = 1'b0;
    end
    if (acc) v1_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) it1_r <= item;
    if (adv2 && v1_r) begin
      it2_r  <= it1_r;
      prod_r <= 54'(it1_r.element_count) * 54'(it1_r.request_size);
    end
  end

  assign size_bad = (it2_r.request_size == '0) || (it2_r.request_size > max_request);

  always_comb begin
    push_cmd.kind   = kind_t'(it2_r.kind);
    push_cmd.hvalid = it2_r.handle_valid;
    push_cmd.hin    = it2_r.handle;
    push_cmd.size   = it2_r.request_size;
    push_cmd.clear  = '0;
    push_cmd.reject = 1'b0;
    unique case (kind_t'(it2_r.kind))
      K_ALLOC:   push_cmd.reject = size_bad;
      K_CALLOC: begin
        push_cmd.reject = (it2_r.element_count == '0) || (prod_r == '0) ||
                          (prod_r > 54'(max_request));
        push_cmd.size   = prod_r[26:0];
        push_cmd.clear  = prod_r[26:0];
      end
      K_FREE:    push_cmd.reject = !it2_r.handle_valid;
      K_REALLOC: push_cmd.reject = size_bad;
      default:   push_cmd.reject = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/ffba_queue.sv]
`default_nettype none
module ffba_queue
  import ffba_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      empty,
  output logic      full
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  cmd_t          ent_r [Q_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CW'(Q_DEPTH));
  assign head  = ent_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) wp_nxt = (wp_r == PW'(Q_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (pop)  rp_nxt = (rp_r == PW'(Q_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_cmd;
  end

endmodule
`default_nettype wire

[hw/rtl/ffba_back.sv]
`default_nettype none
module ffba_back
  import ffba_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int META_BYTES = META_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_empty,
  input  wire cmd_t        q_head,
  input  wire logic [31:0] heap_capacity,
  output logic             pop,
  output logic             busy,
  output logic             out_valid,
  output out_item_t        out_data
);

  localparam int IW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW   = $clog2(MAX_BLOCKS + 1);
  localparam int CMPW = (CW > 8) ? CW : 8;

  typedef enum logic [5:0] {
    B_IDLE  = 6'b000001,
    B_HRD   = 6'b000010,
    B_SCAN  = 6'b000100,
    B_APP   = 6'b001000,
    B_RFREE = 6'b010000,
    B_DONE  = 6'b100000
  } bstate_t;

  bstate_t state_r, state_nxt;
  cmd_t    cmd_r, cmd_nxt;

  entry_t  mem [MAX_BLOCKS];
  entry_t  rd_q, wd;
  logic [IW-1:0] ra, wa;
  logic    we;

  logic [CW-1:0] scan_r, scan_nxt;
  logic [IW-1:0] chk_r, chk_nxt;
  logic          pend_r, pend_nxt;
  logic [26:0]   old_len_r, old_len_nxt;
  logic [31:0]   old_start_r, old_start_nxt;

  logic [CW-1:0] total_r, total_nxt, fcnt_r, fcnt_nxt;
  logic [31:0]   top_r, top_nxt, ubytes_r, ubytes_nxt, fbytes_r, fbytes_nxt;

  logic [1:0]    st_r, st_nxt;
  logic [7:0]    h_r, h_nxt;
  logic [31:0]   off_r, off_nxt;
  logic [26:0]   copy_r, copy_nxt, clr_r, clr_nxt;

  out_item_t     out_r, out_nxt;
  logic          outv_r, outv_nxt;

  logic          re_h;
  logic [33:0]   end_sum;
  logic [31:0]   new_start;

  assign busy      = (state_r != B_IDLE);
  assign out_valid = outv_r;
  assign out_data  = out_r;
  assign re_h      = (cmd_r.kind == K_REALLOC) && cmd_r.hvalid;
  assign end_sum   = 34'(top_r) + 34'(META_BYTES) + 34'(cmd_r.size);
  assign new_start = top_r + 32'(META_BYTES);

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    scan_nxt      = scan_r;
    chk_nxt       = chk_r;
    pend_nxt      = pend_r;
    old_len_nxt   = old_len_r;
    old_start_nxt = old_start_r;
    total_nxt     = total_r;
    fcnt_nxt      = fcnt_r;
    top_nxt       = top_r;
    ubytes_nxt    = ubytes_r;
    fbytes_nxt    = fbytes_r;
    st_nxt        = st_r;
    h_nxt         = h_r;
    off_nxt       = off_r;
    copy_nxt      = copy_r;
    clr_nxt       = clr_r;
    out_nxt       = out_r;
    outv_nxt      = 1'b0;
    pop           = 1'b0;
    we            = 1'b0;
    wa            = '0;
    wd            = '0;
    ra            = IW'(scan_r);
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          pop      = 1'b1;
          cmd_nxt  = q_head;
          st_nxt   = ST_REJ;
          h_nxt    = '0;
          off_nxt  = '0;
          copy_nxt = '0;
          clr_nxt  = '0;
          scan_nxt = '0;
          pend_nxt = 1'b0;
          if (q_head.reject) begin
            state_nxt = B_DONE;
          end else if (q_head.kind == K_FREE ||
                       (q_head.kind == K_REALLOC && q_head.hvalid)) begin
            if (CMPW'(q_head.hin) < CMPW'(total_r)) begin
              ra        = IW'(q_head.hin);
              state_nxt = B_HRD;
            end else begin
              state_nxt = B_DONE;
            end
          end else begin
            state_nxt = B_SCAN;
          end
        end
      end
      B_HRD: begin
        if (rd_q.free) begin
          state_nxt = B_DONE;
        end else if (cmd_r.kind == K_FREE) begin
          we         = 1'b1;
          wa         = IW'(cmd_r.hin);
          wd         = '{len: rd_q.len, free: 1'b1, start: rd_q.start};
          fcnt_nxt   = fcnt_r + 1'b1;
          fbytes_nxt = fbytes_r + 32'(rd_q.len);
          st_nxt     = ST_OK;
          h_nxt      = cmd_r.hin;
          off_nxt    = rd_q.start;
          state_nxt  = B_DONE;
        end else if (rd_q.len >= cmd_r.size) begin
          st_nxt    = ST_OK;
          h_nxt     = cmd_r.hin;
          off_nxt   = rd_q.start;
          state_nxt = B_DONE;
        end else begin
          old_len_nxt   = rd_q.len;
          old_start_nxt = rd_q.start;
          state_nxt     = B_SCAN;
        end
      end
      B_SCAN: begin
        // one entry issued per cycle, checked the cycle after
        if (pend_r && rd_q.free && rd_q.len >= cmd_r.size) begin
          we       = 1'b1;
          wa       = chk_r;
          wd       = '{len: rd_q.len, free: 1'b0, start: rd_q.start};
          if (fcnt_r != '0) fcnt_nxt = fcnt_r - 1'b1;
          fbytes_nxt = (32'(rd_q.len) <= fbytes_r) ? fbytes_r - 32'(rd_q.len) : '0;
          st_nxt   = ST_OK;
          h_nxt    = 8'(chk_r);
          off_nxt  = rd_q.start;
          clr_nxt  = cmd_r.clear;
          if (re_h) begin
            copy_nxt  = old_len_r;
            state_nxt = B_RFREE;
          end else begin
            state_nxt = B_DONE;
          end
        end else if (scan_r < total_r) begin
          pend_nxt = 1'b1;
          chk_nxt  = IW'(scan_r);
          scan_nxt = scan_r + 1'b1;
        end else begin
          state_nxt = B_APP;
        end
      end
      B_APP: begin
        if (total_r == CW'(MAX_BLOCKS) || end_sum > 34'(heap_capacity)) begin
          st_nxt = ST_FULL;
          if (re_h) begin
            h_nxt   = cmd_r.hin;
            off_nxt = old_start_r;
          end
          state_nxt = B_DONE;
        end else begin
          we         = 1'b1;
          wa         = IW'(total_r);
          wd         = '{len: cmd_r.size, free: 1'b0, start: new_start};
          top_nxt    = end_sum[31:0];
          total_nxt  = total_r + 1'b1;
          ubytes_nxt = ubytes_r + 32'(cmd_r.size);
          st_nxt     = ST_OK;
          h_nxt      = 8'(total_r);
          off_nxt    = new_start;
          clr_nxt    = cmd_r.clear;
          if (re_h) begin
            copy_nxt  = old_len_r;
            state_nxt = B_RFREE;
          end else begin
            state_nxt = B_DONE;
          end
        end
      end
      B_RFREE: begin
        we         = 1'b1;
        wa         = IW'(cmd_r.hin);
        wd         = '{len: old_len_r, free: 1'b1, start: old_start_r};
        fcnt_nxt   = fcnt_r + 1'b1;
        fbytes_nxt = fbytes_r + 32'(old_len_r);
        state_nxt  = B_DONE;
      end
      B_DONE: begin
        out_nxt.status           = st_r;
        out_nxt.result_handle    = h_r;
        out_nxt.data_offset      = off_r;
        out_nxt.copy_bytes       = copy_r;
        out_nxt.clear_bytes      = clr_r;
        out_nxt.allocated_blocks = 9'(total_r);
        out_nxt.free_blocks      = 9'(fcnt_r);
        out_nxt.allocated_bytes  = ubytes_r;
        out_nxt.free_bytes       = fbytes_r;
        outv_nxt  = 1'b1;
        state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      pend_r   <= 1'b0;
      total_r  <= '0;
      fcnt_r   <= '0;
      top_r    <= '0;
      ubytes_r <= '0;
      fbytes_r <= '0;
      outv_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pend_r   <= pend_nxt;
      total_r  <= total_nxt;
      fcnt_r   <= fcnt_nxt;
      top_r    <= top_nxt;
      ubytes_r <= ubytes_nxt;
      fbytes_r <= fbytes_nxt;
      outv_r   <= outv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    scan_r      <= scan_nxt;
    chk_r       <= chk_nxt;
    old_len_r   <= old_len_nxt;
    old_start_r <= old_start_nxt;
    st_r        <= st_nxt;
    h_r         <= h_nxt;
    off_r       <= off_nxt;
    copy_r      <= copy_nxt;
    clr_r       <= clr_nxt;
    out_r       <= out_nxt;
  end

endmodule
`default_nettype wire

[hw/rtl/first_fit_block_allocator.sv]
// Channel  | Handshake                 | Payload
// input    | start / busy              | in_data  (in_item_t)
// result   | out_valid strobe, 1 cycle | out_data (out_item_t)
// config   | APB write/read            | pwdata / prdata, paddr
//
// One item at a time. Front stage: input register, then the calloc multiply,
// then through the queue. Back: free reads the handle entry and marks it free;
// alloc/calloc scan the table, then append; realloc may also free the old entry.
// The worst case is set by the one-entry-per-cycle first-fit scan
// of the block table memory.
// Reset is synchronous, active low; the table needs no clearing pass.
// The receiver cannot stall: each result shows for exactly one cycle.
`default_nettype none
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int META_BYTES = META_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  output out_item_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [26:0] maxreq_r;
  logic [31:0] cap_r;
  logic        acc, push, pop, q_empty, q_full, f_busy, b_busy;
  cmd_t        push_cmd, q_head;

  assign pready = 1'b1;
  assign acc    = start && !busy;
  assign busy   = f_busy || !q_empty || b_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxreq_r <= MAX_REQUEST_RST;
      cap_r    <= HEAP_CAP_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == ADDR_HEAP_CAP[2]) cap_r <= pwdata;
      else maxreq_r <= pwdata[26:0];
    end
  end

  assign prdata = (paddr[2] == ADDR_HEAP_CAP[2]) ? cap_r : 32'(maxreq_r);

  ffba_front u_front (
    .clk, .rst_n, .acc, .item(in_data), .max_request(maxreq_r),
    .q_full, .push_cmd, .push, .busy(f_busy)
  );

  ffba_queue u_queue (
    .clk, .rst_n, .push, .push_cmd, .pop, .head(q_head),
    .empty(q_empty), .full(q_full)
  );

  ffba_back #(.MAX_BLOCKS(MAX_BLOCKS), .META_BYTES(META_BYTES)) u_back (
    .clk, .rst_n, .q_empty, .q_head, .heap_capacity(cap_r), .pop,
    .busy(b_busy), .out_valid, .out_data
  );

endmodule
`default_nettype wire

[hw/rtl/ffba_chk.sv]
`default_nettype none
module ffba_chk
  import ffba_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire out_item_t out_data,
  input wire logic      out_valid,
  input wire logic      pready
);

  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after accept");

  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_REJ ||
                   out_data.status == ST_FULL)) else $error("bad status code");

  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.free_blocks <= out_data.allocated_blocks)
    else $error("free blocks exceed table size");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    pready) else $error("pready low");

endmodule

bind first_fit_block_allocator ffba_chk u_ffba_chk (.*);
`default_nettype wire
